// ===== hdl/cmp_pkg.sv =====
// ----------------------------------------------------------------------------
// cmp_pkg
// shared types and codes of the coap message parser: record layout,
// record kinds, error codes and protocol constants
// ----------------------------------------------------------------------------
package cmp_pkg;

	// depth of the record queue between parser and output stage
	localparam int unsigned QueueDepth = 2;

	// record kinds
	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_TOKEN   = 3'd1;
	localparam logic [2:0] KIND_OPTION  = 3'd2;
	localparam logic [2:0] KIND_OPTDATA = 3'd3;
	localparam logic [2:0] KIND_PAYLOAD = 3'd4;
	localparam logic [2:0] KIND_END     = 3'd5;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_SHORT    = 3'd1;
	localparam logic [2:0] ERR_TOKEN    = 3'd2;
	localparam logic [2:0] ERR_DELTA    = 3'd3;
	localparam logic [2:0] ERR_LENGTH   = 3'd4;
	localparam logic [2:0] ERR_TRUNC    = 3'd5;
	localparam logic [2:0] ERR_OVERFLOW = 3'd6;

	// protocol constants
	localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
	localparam logic [3:0] NIB_EXT8       = 4'd13;
	localparam logic [3:0] NIB_EXT16      = 4'd14;
	localparam logic [3:0] NIB_RESERVED   = 4'd15;
	localparam logic [3:0] TOKEN_MAX      = 4'd8;
	localparam int unsigned Ext8Bias      = 13;
	localparam int unsigned Ext16Bias     = 269;

	// one result record
	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  version;
		logic [1:0]  msg_type;
		logic [3:0]  token_length;
		logic [7:0]  code;
		logic [15:0] message_id;
		logic [15:0] option_number;
		logic [15:0] option_length;
		logic [7:0]  data_byte;
		logic        is_last;
		logic [2:0]  error;
	} rec_t;

endpackage

// ===== hdl/coap_message_parser.sv =====
// ----------------------------------------------------------------------------
// coap_message_parser
// byte-serial parser for coap datagrams: header record, token bytes, option
// headers with resolved numbers and lengths, option data and payload bytes
// ----------------------------------------------------------------------------
//
// channel   direction  word                        handshake
// byte      in         byte_value, last_byte       byte_valid / byte_stall
// rec       out        kind .. error (record)      rec_valid / rec_stall
//
// one byte per cycle when not stalled; every byte updates the parse state
// in the cycle it is taken, so the parser loop never waits on its own result
// a record passes the record queue and then the output register to rec_valid
// byte_stall rises only when the record queue is full, i.e. when the
// receiving side has held rec_stall long enough to back the queue up
// reset clears all control state at once; the parser starts in the header
// phase and needs no setup cycles
//
module coap_message_parser import cmp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic        byte_valid,
	output logic        byte_stall,
	// record channel
	output logic [2:0]  kind,
	output logic [1:0]  version,
	output logic [1:0]  msg_type,
	output logic [3:0]  token_length,
	output logic [7:0]  code,
	output logic [15:0] message_id,
	output logic [15:0] option_number,
	output logic [15:0] option_length,
	output logic [7:0]  data_byte,
	output logic        is_last,
	output logic [2:0]  error,
	output logic        rec_valid,
	input  logic        rec_stall
);

	// parser to queue
	logic push;
	rec_t push_rec;
	logic full;

	// queue to output stage
	logic pop;
	rec_t pop_rec;
	logic empty;

	rec_t out_rec;

	// front: takes bytes, runs the phase machine, makes records
	cmp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.full       (full),
		.push       (push),
		.push_rec   (push_rec)
	);

	// decouples the parser from output back pressure
	cmp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (empty)
	);

	// back: output register on the record channel
	cmp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_rec   (pop_rec),
		.pop       (pop),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.out_rec   (out_rec)
	);

	// record fields out to ports
	assign kind          = out_rec.kind;
	assign version       = out_rec.version;
	assign msg_type      = out_rec.msg_type;
	assign token_length  = out_rec.token_length;
	assign code          = out_rec.code;
	assign message_id    = out_rec.message_id;
	assign option_number = out_rec.option_number;
	assign option_length = out_rec.option_length;
	assign data_byte     = out_rec.data_byte;
	assign is_last       = out_rec.is_last;
	assign error         = out_rec.error;

endmodule

// ===== hdl/cmp_front.sv =====
// ----------------------------------------------------------------------------
// cmp_front
// byte acceptance and parse state machine; turns each byte into zero or one
// record and pushes it into the record queue
// ----------------------------------------------------------------------------
module cmp_front import cmp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic       full,
	output logic       push,
	output rec_t       push_rec
);

	typedef enum logic [7:0] {
		PH_HEADER    = 8'b0000_0001,
		PH_TOKEN     = 8'b0000_0010,
		PH_OPT       = 8'b0000_0100,
		PH_DELTA_EXT = 8'b0000_1000,
		PH_LEN_EXT   = 8'b0001_0000,
		PH_DATA      = 8'b0010_0000,
		PH_PAYLOAD   = 8'b0100_0000,
		PH_DRAIN     = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  hdr_cnt_q, hdr_cnt_n;
	logic [23:0] hdr_hold_q, hdr_hold_n;
	logic [3:0]  tok_left_q, tok_left_n;
	logic [15:0] opt_base_q, opt_base_n;
	logic [3:0]  dnib_q, dnib_n;
	logic [3:0]  lnib_q, lnib_n;
	logic        ext_cnt_q, ext_cnt_n;
	logic [7:0]  ext_hold_q, ext_hold_n;
	logic [16:0] opt_left_q, opt_left_n;
	logic [2:0]  err_q, err_n;

	logic        accept;
	logic        emit;
	rec_t        rec_n;
	logic        do_fail;
	logic [2:0]  fail_code;
	logic        want_after;
	logic [3:0]  ln_src;
	logic        want_fin;
	logic [16:0] fin_len;
	logic [17:0] sum;
	logic [16:0] ext8_val;
	logic [16:0] ext16_val;
	logic [3:0]  tkl;
	logic [2:0]  hdr_err;

	assign byte_stall = full;
	assign accept     = byte_valid & ~full;
	assign push       = accept & emit;
	assign push_rec   = rec_n;

	assign tkl       = hdr_hold_q[19:16];
	assign ext8_val  = 17'(byte_value) + 17'(Ext8Bias);
	assign ext16_val = {1'b0, ext_hold_q, byte_value} + 17'(Ext16Bias);

	always_comb begin
		phase_n    = phase_q;
		hdr_cnt_n  = hdr_cnt_q;
		hdr_hold_n = hdr_hold_q;
		tok_left_n = tok_left_q;
		opt_base_n = opt_base_q;
		dnib_n     = dnib_q;
		lnib_n     = lnib_q;
		ext_cnt_n  = ext_cnt_q;
		ext_hold_n = ext_hold_q;
		opt_left_n = opt_left_q;
		err_n      = err_q;
		emit       = 1'b0;
		rec_n      = '0;
		do_fail    = 1'b0;
		fail_code  = ERR_NONE;
		want_after = 1'b0;
		ln_src     = lnib_q;
		want_fin   = 1'b0;
		fin_len    = '0;
		sum        = '0;
		hdr_err    = ERR_NONE;

		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_cnt_q != 2'd3) begin
					hdr_hold_n = {hdr_hold_q[15:0], byte_value};
					hdr_cnt_n  = hdr_cnt_q + 2'd1;
					if (last_byte) begin
						do_fail   = 1'b1;
						fail_code = ERR_SHORT;
					end
				end else begin
					if (tkl > TOKEN_MAX)
						hdr_err = ERR_TOKEN;
					else if (last_byte && tkl != 4'd0)
						hdr_err = ERR_TRUNC;
					emit               = 1'b1;
					rec_n.kind         = KIND_HEADER;
					rec_n.version      = hdr_hold_q[23:22];
					rec_n.msg_type     = hdr_hold_q[21:20];
					rec_n.token_length = tkl;
					rec_n.code         = hdr_hold_q[15:8];
					rec_n.message_id   = {hdr_hold_q[7:0], byte_value};
					rec_n.error        = hdr_err;
					hdr_cnt_n          = 2'd0;
					if (hdr_err != ERR_NONE) begin
						err_n   = hdr_err;
						phase_n = PH_DRAIN;
					end else begin
						tok_left_n = tkl;
						phase_n    = (tkl != 4'd0) ? PH_TOKEN : PH_OPT;
					end
				end
			end
			PH_TOKEN: begin
				tok_left_n = tok_left_q - 4'd1;
				if (last_byte && tok_left_n != 4'd0) begin
					do_fail   = 1'b1;
					fail_code = ERR_TRUNC;
				end else begin
					emit            = 1'b1;
					rec_n.kind      = KIND_TOKEN;
					rec_n.data_byte = byte_value;
					if (tok_left_n == 4'd0)
						phase_n = PH_OPT;
				end
			end
			PH_OPT: begin
				if (byte_value == PAYLOAD_MARKER) begin
					phase_n = PH_PAYLOAD;
					if (last_byte) begin
						do_fail   = 1'b1;
						fail_code = ERR_TRUNC;
					end
				end else begin
					dnib_n     = byte_value[7:4];
					lnib_n     = byte_value[3:0];
					ext_cnt_n  = 1'b0;
					ext_hold_n = 8'd0;
					if (byte_value[7:4] == NIB_RESERVED) begin
						do_fail   = 1'b1;
						fail_code = ERR_DELTA;
					end else if (byte_value[3:0] == NIB_RESERVED) begin
						do_fail   = 1'b1;
						fail_code = ERR_LENGTH;
					end else if (byte_value[7:4] >= NIB_EXT8) begin
						phase_n = PH_DELTA_EXT;
						if (last_byte) begin
							do_fail   = 1'b1;
							fail_code = ERR_TRUNC;
						end
					end else begin
						sum = {2'b00, opt_base_q} + 18'(byte_value[7:4]);
						if (sum[17:16] != 2'b00) begin
							do_fail   = 1'b1;
							fail_code = ERR_OVERFLOW;
						end else begin
							opt_base_n = sum[15:0];
							ln_src     = byte_value[3:0];
							want_after = 1'b1;
						end
					end
				end
			end
			PH_DELTA_EXT: begin
				if (dnib_q != NIB_EXT8 && !ext_cnt_q) begin
					// first byte of a two-byte extension
					ext_hold_n = byte_value;
					ext_cnt_n  = 1'b1;
					if (last_byte) begin
						do_fail   = 1'b1;
						fail_code = ERR_TRUNC;
					end
				end else begin
					ext_cnt_n = 1'b0;
					sum = {2'b00, opt_base_q}
						+ {1'b0, (dnib_q == NIB_EXT8) ? ext8_val : ext16_val};
					if (sum[17:16] != 2'b00) begin
						do_fail   = 1'b1;
						fail_code = ERR_OVERFLOW;
					end else begin
						opt_base_n = sum[15:0];
						ln_src     = lnib_q;
						want_after = 1'b1;
					end
				end
			end
			PH_LEN_EXT: begin
				if (lnib_q != NIB_EXT8 && !ext_cnt_q) begin
					ext_hold_n = byte_value;
					ext_cnt_n  = 1'b1;
					if (last_byte) begin
						do_fail   = 1'b1;
						fail_code = ERR_TRUNC;
					end
				end else begin
					ext_cnt_n = 1'b0;
					want_fin  = 1'b1;
					fin_len   = (lnib_q == NIB_EXT8) ? ext8_val : ext16_val;
				end
			end
			PH_DATA: begin
				opt_left_n = opt_left_q - 17'd1;
				if (last_byte && opt_left_n != 17'd0) begin
					do_fail   = 1'b1;
					fail_code = ERR_TRUNC;
				end else begin
					emit            = 1'b1;
					rec_n.kind      = KIND_OPTDATA;
					rec_n.data_byte = byte_value;
					if (opt_left_n == 17'd0)
						phase_n = PH_OPT;
				end
			end
			PH_PAYLOAD: begin
				emit            = 1'b1;
				rec_n.kind      = KIND_PAYLOAD;
				rec_n.data_byte = byte_value;
			end
			PH_DRAIN: begin
				if (last_byte) begin
					emit        = 1'b1;
					rec_n.kind  = KIND_END;
					rec_n.error = err_q;
				end
			end
			default: begin
			end
		endcase

		// delta resolved: decide on the length nibble
		if (want_after) begin
			if (ln_src == NIB_EXT8 || ln_src == NIB_EXT16) begin
				ext_cnt_n = 1'b0;
				phase_n   = PH_LEN_EXT;
				if (last_byte) begin
					do_fail   = 1'b1;
					fail_code = ERR_TRUNC;
				end
			end else begin
				want_fin = 1'b1;
				fin_len  = 17'(ln_src);
			end
		end

		// length resolved: option header record
		if (want_fin) begin
			if (fin_len[16]) begin
				do_fail   = 1'b1;
				fail_code = ERR_OVERFLOW;
			end else if (last_byte && fin_len != 17'd0) begin
				do_fail   = 1'b1;
				fail_code = ERR_TRUNC;
			end else begin
				opt_left_n          = fin_len;
				emit                = 1'b1;
				rec_n.kind          = KIND_OPTION;
				rec_n.option_number = opt_base_n;
				rec_n.option_length = fin_len[15:0];
				phase_n             = (fin_len != 17'd0) ? PH_DATA : PH_OPT;
			end
		end

		// error at this byte: no record unless it ends the datagram
		if (do_fail) begin
			err_n   = fail_code;
			phase_n = PH_DRAIN;
			emit    = last_byte;
			rec_n   = '0;
			if (last_byte) begin
				rec_n.kind  = KIND_END;
				rec_n.error = fail_code;
			end
		end

		rec_n.is_last = last_byte;

		// datagram done: start over
		if (last_byte) begin
			phase_n    = PH_HEADER;
			hdr_cnt_n  = 2'd0;
			hdr_hold_n = 24'd0;
			tok_left_n = 4'd0;
			opt_base_n = 16'd0;
			dnib_n     = 4'd0;
			lnib_n     = 4'd0;
			ext_cnt_n  = 1'b0;
			ext_hold_n = 8'd0;
			opt_left_n = 17'd0;
			err_n      = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= 2'd0;
			hdr_hold_q <= 24'd0;
			tok_left_q <= 4'd0;
			opt_base_q <= 16'd0;
			dnib_q     <= 4'd0;
			lnib_q     <= 4'd0;
			ext_cnt_q  <= 1'b0;
			ext_hold_q <= 8'd0;
			opt_left_q <= 17'd0;
			err_q      <= ERR_NONE;
		end else if (accept) begin
			phase_q    <= phase_n;
			hdr_cnt_q  <= hdr_cnt_n;
			hdr_hold_q <= hdr_hold_n;
			tok_left_q <= tok_left_n;
			opt_base_q <= opt_base_n;
			dnib_q     <= dnib_n;
			lnib_q     <= lnib_n;
			ext_cnt_q  <= ext_cnt_n;
			ext_hold_q <= ext_hold_n;
			opt_left_q <= opt_left_n;
			err_q      <= err_n;
		end
	end

endmodule

// ===== hdl/cmp_queue.sv =====
// ----------------------------------------------------------------------------
// cmp_queue
// short record queue between parser and output stage
// ----------------------------------------------------------------------------
module cmp_queue import cmp_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output rec_t pop_rec,
	output logic empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rec_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_rec = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// ===== hdl/cmp_back.sv =====
// ----------------------------------------------------------------------------
// cmp_back
// output register: takes records from the queue and holds them until the
// receiving side takes them
// ----------------------------------------------------------------------------
module cmp_back import cmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  rec_t pop_rec,
	output logic pop,
	output logic rec_valid,
	input  logic rec_stall,
	output rec_t out_rec
);

	logic out_valid_q;
	rec_t out_rec_q;
	logic load;

	assign load      = ~out_valid_q | ~rec_stall;
	assign pop       = load & ~empty;
	assign rec_valid = out_valid_q;
	assign out_rec   = out_rec_q;

	always_ff @(posedge clk) begin
		if (pop)
			out_rec_q <= pop_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= ~empty;
	end

endmodule

// ===== hdl/cmp_checker.sv =====
// ----------------------------------------------------------------------------
// cmp_checker
// port-level checks on the record channel of the coap message parser
// ----------------------------------------------------------------------------
module cmp_checker import cmp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic [2:0]  kind,
	input logic [1:0]  version,
	input logic [1:0]  msg_type,
	input logic [3:0]  token_length,
	input logic [7:0]  code,
	input logic [15:0] message_id,
	input logic [15:0] option_number,
	input logic [15:0] option_length,
	input logic [7:0]  data_byte,
	input logic        is_last,
	input logic [2:0]  error,
	input logic        rec_valid,
	input logic        rec_stall
);

	// a stalled record stays put
	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> rec_valid && $stable(kind) && $stable(data_byte)
			&& $stable(error) && $stable(is_last))
		else $error("record changed while stalled");

	// errors only ride on header or end records
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && error != ERR_NONE |-> kind == KIND_HEADER || kind == KIND_END)
		else $error("error on a data record");

	// an end record always closes the datagram
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && kind == KIND_END |-> is_last)
		else $error("end record without is_last");

	// option fields are zero outside option header records
	a_opt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && kind != KIND_OPTION |-> option_number == 16'd0
			&& option_length == 16'd0)
		else $error("option fields set on a non-option record");

	// header fields are zero outside header records
	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && kind != KIND_HEADER |-> message_id == 16'd0 && code == 8'd0
			&& token_length == 4'd0 && version == 2'd0 && msg_type == 2'd0)
		else $error("header fields set on a non-header record");

endmodule

bind coap_message_parser cmp_checker u_cmp_checker (.*);
